### hdl/slpg_pkg.sv
// Shared types, codes and timing constants of the status LED pattern generator.
package slpg_pkg;

   // Field widths.
   localparam int PATTERN_W = 2;
   localparam int STRIP_W   = 10;
   localparam int PHASE_W   = 3;
   localparam int WAIT_W    = 10;
   localparam int LEVEL_W   = 6;
   localparam int COLOR_W   = 8;
   localparam int LIT_W     = 2;

   // Number of pixels used for the indicator at the start of the strip.
   localparam logic [STRIP_W-1:0] INDICATOR_PIXELS = STRIP_W'(3);
   localparam logic [STRIP_W-1:0] STRIP_RESET      = STRIP_W'(3);

   // Commanded pattern codes.
   localparam logic [PATTERN_W-1:0] PAT_NONE         = 2'd0;
   localparam logic [PATTERN_W-1:0] PAT_NO_LINK      = 2'd1;
   localparam logic [PATTERN_W-1:0] PAT_CONFIG_ERROR = 2'd2;
   localparam logic [PATTERN_W-1:0] PAT_SETUP        = 2'd3;

   // Sequencer phases inside one pattern cycle.
   localparam logic [PHASE_W-1:0] PHASE_BOUNDARY = 3'd0;
   localparam logic [PHASE_W-1:0] PHASE_FIRST    = 3'd1;
   localparam logic [PHASE_W-1:0] PHASE_SECOND   = 3'd2;
   localparam logic [PHASE_W-1:0] PHASE_PAUSE    = 3'd3;

   // Colors.
   localparam logic [COLOR_W-1:0] RED_LEVEL    = 8'd80;
   localparam logic [COLOR_W-1:0] YELLOW_GREEN = 8'd60;
   localparam logic [LEVEL_W-1:0] PULSE_TOP    = 6'd40;
   localparam logic [LEVEL_W-1:0] PULSE_STEP   = 6'd2;

   // Wait loads: a wait of N ms loads N - 1.
   localparam logic [WAIT_W-1:0] BLINK_WAIT = WAIT_W'(1000 - 1);
   localparam logic [WAIT_W-1:0] ALT_WAIT   = WAIT_W'(200 - 1);
   localparam logic [WAIT_W-1:0] STEP_WAIT  = WAIT_W'(50 - 1);
   localparam logic [WAIT_W-1:0] PAUSE_WAIT = WAIT_W'(200 - 1);
   localparam logic [WAIT_W-1:0] IDLE_WAIT  = WAIT_W'(500 - 1);

   // One input item: a millisecond tick with its command.
   typedef struct packed {
      logic [PATTERN_W-1:0] pattern;
      logic                 stop_request;
      logic                 lamp_on;
   } item_type;

   // One result item.
   typedef struct packed {
      logic                 paint;
      logic                 wipe;
      logic                 restore;
      logic [COLOR_W-1:0]   red;
      logic [COLOR_W-1:0]   green;
      logic [COLOR_W-1:0]   blue;
      logic [LIT_W-1:0]     lit_pixels;
      logic                 active;
      logic [PATTERN_W-1:0] shown_pattern;
   } result_type;

   // Sequencer state.
   typedef struct packed {
      logic                 running;
      logic [PATTERN_W-1:0] last_shown;
      logic [PATTERN_W-1:0] cycle_pattern;
      logic [PHASE_W-1:0]   phase;
      logic [WAIT_W-1:0]    wait_left;
      logic [LEVEL_W-1:0]   level;
      logic                 stopping;
   } seq_state_type;

   // Indicator pixel count capped by the strip size.
   function automatic logic [LIT_W-1:0] lit_count(input logic [STRIP_W-1:0] strip_pixels);
      logic [STRIP_W-1:0] capped;
      capped = (strip_pixels < INDICATOR_PIXELS) ? strip_pixels : INDICATOR_PIXELS;
      return capped[LIT_W-1:0];
   endfunction

endpackage

### hdl/slpg_in_stage.sv
// Input register of the pattern generator with its stall handshake.
module slpg_in_stage (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  slpg_pkg::item_type          req_item,
   input  logic                        take,
   output logic                        item_valid,
   output slpg_pkg::item_type          item
);

   logic               item_valid_ff;
   slpg_pkg::item_type item_ff;
   logic               load;

   // The register takes a new item when it is empty or its item moves on.
   assign load      = !item_valid_ff || take;
   assign req_stall = !load;

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else if (load) begin
         item_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load && req_valid) begin
         item_ff <= req_item;
      end
   end

   assign item_valid = item_valid_ff;
   assign item       = item_ff;

endmodule

### hdl/slpg_sequencer.sv
// Pattern sequencer: state registers and the per-tick step logic.
module slpg_sequencer (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              advance,
   input  slpg_pkg::item_type                item,
   input  logic [slpg_pkg::STRIP_W-1:0]      strip_pixels,
   output slpg_pkg::result_type              result
);

   slpg_pkg::seq_state_type state_ff;
   slpg_pkg::seq_state_type state_in;
   slpg_pkg::result_type    res;
   logic [slpg_pkg::PATTERN_W-1:0] cmd;
   logic                    step;
   logic                    act;

   // A stop request reads as pattern none.
   assign cmd = item.stop_request ? slpg_pkg::PAT_NONE : item.pattern;

   always_comb begin
      state_in = state_ff;
      res      = '0;
      step     = 1'b0;
      act      = 1'b0;

      // Start from idle, or count down the current wait.
      if (!state_ff.running) begin
         if (cmd != slpg_pkg::PAT_NONE) begin
            state_in = '0;
            state_in.running = 1'b1;
            step = 1'b1;
         end
      end else begin
         if (item.stop_request) begin
            state_in.stopping = 1'b1;
         end
         if (state_ff.wait_left != '0) begin
            state_in.wait_left = state_ff.wait_left - 1'b1;
         end else begin
            step = 1'b1;
         end
      end

      // Cycle boundary: exit on stop, otherwise begin a new cycle.
      if (step) begin
         if (state_in.phase == slpg_pkg::PHASE_BOUNDARY) begin
            if (state_in.stopping) begin
               if (item.lamp_on) begin
                  res.restore = 1'b1;
               end else begin
                  res.wipe = 1'b1;
               end
               state_in.running       = 1'b0;
               state_in.stopping      = 1'b0;
               state_in.last_shown    = slpg_pkg::PAT_NONE;
               state_in.cycle_pattern = slpg_pkg::PAT_NONE;
               state_in.level         = '0;
            end else begin
               if (cmd != state_in.last_shown) begin
                  res.wipe = 1'b1;
                  state_in.last_shown = cmd;
               end
               state_in.cycle_pattern = cmd;
               state_in.level         = '0;
               state_in.phase         = slpg_pkg::PHASE_FIRST;
               act = 1'b1;
            end
         end else begin
            act = 1'b1;
         end
      end

      // Pattern action for the current phase, ending in a wait.
      if (act) begin
         unique case (state_in.cycle_pattern)
            slpg_pkg::PAT_NO_LINK: begin
               state_in.wait_left = slpg_pkg::BLINK_WAIT;
               if (state_in.phase == slpg_pkg::PHASE_FIRST) begin
                  res.paint = 1'b1;
                  res.red   = slpg_pkg::RED_LEVEL;
                  state_in.phase = slpg_pkg::PHASE_SECOND;
               end else begin
                  res.wipe = 1'b1;
                  state_in.phase = slpg_pkg::PHASE_BOUNDARY;
               end
            end
            slpg_pkg::PAT_CONFIG_ERROR: begin
               state_in.wait_left = slpg_pkg::ALT_WAIT;
               res.paint = 1'b1;
               res.red   = slpg_pkg::RED_LEVEL;
               if (state_in.phase == slpg_pkg::PHASE_FIRST) begin
                  state_in.phase = slpg_pkg::PHASE_SECOND;
               end else begin
                  res.green = slpg_pkg::YELLOW_GREEN;
                  state_in.phase = slpg_pkg::PHASE_BOUNDARY;
               end
            end
            slpg_pkg::PAT_SETUP: begin
               if (state_in.phase == slpg_pkg::PHASE_FIRST) begin
                  if (state_in.stopping) begin
                     // Ramps are cut short; only the pause remains.
                     state_in.level     = slpg_pkg::PULSE_TOP;
                     state_in.wait_left = slpg_pkg::PAUSE_WAIT;
                     state_in.phase     = slpg_pkg::PHASE_BOUNDARY;
                  end else if (state_in.level > slpg_pkg::PULSE_TOP) begin
                     // Top reached: first step of the falling ramp.
                     res.paint = 1'b1;
                     res.blue  = slpg_pkg::COLOR_W'(slpg_pkg::PULSE_TOP);
                     state_in.level     = slpg_pkg::PULSE_TOP - slpg_pkg::PULSE_STEP;
                     state_in.wait_left = slpg_pkg::STEP_WAIT;
                     state_in.phase     = slpg_pkg::PHASE_SECOND;
                  end else begin
                     res.paint = 1'b1;
                     res.blue  = slpg_pkg::COLOR_W'(state_in.level);
                     state_in.level     = state_in.level + slpg_pkg::PULSE_STEP;
                     state_in.wait_left = slpg_pkg::STEP_WAIT;
                  end
               end else if (state_in.phase == slpg_pkg::PHASE_SECOND) begin
                  if (state_in.stopping) begin
                     state_in.wait_left = slpg_pkg::PAUSE_WAIT;
                     state_in.phase     = slpg_pkg::PHASE_BOUNDARY;
                  end else begin
                     res.paint = 1'b1;
                     res.blue  = slpg_pkg::COLOR_W'(state_in.level);
                     state_in.wait_left = slpg_pkg::STEP_WAIT;
                     if (state_in.level < slpg_pkg::PULSE_STEP) begin
                        state_in.level = '0;
                        state_in.phase = slpg_pkg::PHASE_PAUSE;
                     end else begin
                        state_in.level = state_in.level - slpg_pkg::PULSE_STEP;
                     end
                  end
               end else begin
                  state_in.wait_left = slpg_pkg::PAUSE_WAIT;
                  state_in.phase     = slpg_pkg::PHASE_BOUNDARY;
               end
            end
            default: begin
               state_in.wait_left = slpg_pkg::IDLE_WAIT;
               state_in.phase     = slpg_pkg::PHASE_BOUNDARY;
            end
         endcase
      end

      // Report fields.
      res.lit_pixels    = res.paint ? slpg_pkg::lit_count(strip_pixels) : '0;
      res.active        = state_in.running;
      res.shown_pattern = cmd;
   end

   // State moves on only when the item is handed to the result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   assign result = res;

endmodule

### hdl/slpg_out_stage.sv
// Result register of the pattern generator with its stall handshake.
module slpg_out_stage (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 item_valid,
   input  slpg_pkg::result_type result,
   output logic                 take,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output slpg_pkg::result_type rsp_result
);

   logic                 rsp_valid_ff;
   slpg_pkg::result_type result_ff;
   logic                 open;

   // The register is free when empty or when its item leaves this cycle.
   assign open = !rsp_valid_ff || !rsp_stall;
   assign take = item_valid && open;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (open) begin
         rsp_valid_ff <= item_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         result_ff <= result;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_result = result_ff;

endmodule

### hdl/status_led_pattern_generator_top.sv
// Top level of the status LED pattern generator.
//
// Each req item is one millisecond tick carrying the commanded pattern, a stop
// request and the lamp power state. For every accepted item exactly one rsp
// item comes back, telling whether the indicator pixels are painted (and in
// which color), whether the strip is wiped or the normal frame restored, the
// lit pixel count, whether the sequencer runs and the reported pattern.
// The csr channel writes the strip size; it is always ready and is meant to
// be written while no item is in flight.
// An item passes an input register and a result register: it is accepted into
// the input register, then moves into the result register, where rsp_valid
// shows it; one item is taken every cycle while rsp_stall is low. The sequencer
// step between the registers is a wait counter and a short pattern decode.
// Synchronous reset empties both registers, stops the sequencer and sets the
// strip size to three. When rsp_stall is high the result holds; an empty
// input register still takes one more item, then req_stall rises until the
// result is taken.
module status_led_pattern_generator_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [slpg_pkg::PATTERN_W-1:0]      req_pattern,
   input  logic                                req_stop_request,
   input  logic                                req_lamp_on,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_paint,
   output logic                                rsp_wipe,
   output logic                                rsp_restore,
   output logic [slpg_pkg::COLOR_W-1:0]        rsp_red,
   output logic [slpg_pkg::COLOR_W-1:0]        rsp_green,
   output logic [slpg_pkg::COLOR_W-1:0]        rsp_blue,
   output logic [slpg_pkg::LIT_W-1:0]          rsp_lit_pixels,
   output logic                                rsp_active,
   output logic [slpg_pkg::PATTERN_W-1:0]      rsp_shown_pattern,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [slpg_pkg::STRIP_W-1:0]        csr_strip_pixels
);

   slpg_pkg::item_type   req_item;
   slpg_pkg::item_type   item;
   slpg_pkg::result_type result;
   slpg_pkg::result_type rsp_result;
   logic                 item_valid;
   logic                 take;
   logic [slpg_pkg::STRIP_W-1:0] strip_pixels_ff;

   // Strip size register.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         strip_pixels_ff <= slpg_pkg::STRIP_RESET;
      end else if (csr_valid && csr_ready) begin
         strip_pixels_ff <= csr_strip_pixels;
      end
   end

   assign req_item.pattern      = req_pattern;
   assign req_item.stop_request = req_stop_request;
   assign req_item.lamp_on      = req_lamp_on;

   slpg_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_item   (req_item),
      .take       (take),
      .item_valid (item_valid),
      .item       (item)
   );

   slpg_sequencer u_sequencer (
      .clock        (clock),
      .reset        (reset),
      .advance      (take),
      .item         (item),
      .strip_pixels (strip_pixels_ff),
      .result       (result)
   );

   slpg_out_stage u_out_stage (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .result     (result),
      .take       (take),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_result (rsp_result)
   );

   assign rsp_paint         = rsp_result.paint;
   assign rsp_wipe          = rsp_result.wipe;
   assign rsp_restore       = rsp_result.restore;
   assign rsp_red           = rsp_result.red;
   assign rsp_green         = rsp_result.green;
   assign rsp_blue          = rsp_result.blue;
   assign rsp_lit_pixels    = rsp_result.lit_pixels;
   assign rsp_active        = rsp_result.active;
   assign rsp_shown_pattern = rsp_result.shown_pattern;

endmodule

### hdl/slpg_checker.sv
// Port-level checks of the status LED pattern generator and their binding.
module slpg_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               rsp_valid,
   input logic                               rsp_stall,
   input logic                               rsp_paint,
   input logic                               rsp_wipe,
   input logic                               rsp_restore,
   input logic [slpg_pkg::COLOR_W-1:0]       rsp_red,
   input logic [slpg_pkg::COLOR_W-1:0]       rsp_green,
   input logic [slpg_pkg::COLOR_W-1:0]       rsp_blue,
   input logic [slpg_pkg::LIT_W-1:0]         rsp_lit_pixels,
   input logic                               rsp_active
);

   // Colors and pixel count are zero when nothing is painted.
   a_unpainted_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_paint |->
         rsp_red == '0 && rsp_green == '0 && rsp_blue == '0 && rsp_lit_pixels == '0)
      else $error("color or pixel count set without paint");

   // A restore happens only at exit, with nothing else written.
   a_restore_exit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_restore |-> !rsp_active && !rsp_wipe && !rsp_paint)
      else $error("restore outside of exit");

   // Painting happens only while the sequencer runs.
   a_paint_active: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_paint |-> rsp_active)
      else $error("paint while idle");

   // A stalled result stays put.
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=>
         rsp_valid && $stable(rsp_paint) && $stable(rsp_blue) && $stable(rsp_active))
      else $error("result changed under stall");

endmodule

bind status_led_pattern_generator_top slpg_checker u_slpg_checker (.*);
